// File: rtl/assert_macros.svh
// Assertion macros for the RTL, included by the decoder core.
// Both forms expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge while reset is released.
`define MSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked on every rising clock edge, during reset too.
`define MSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define MSD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg
// Constants and the character table of the Morse symbol decoder.
// ----------------------------------------------------------------------------
package msd_pkg;

  // Tree geometry: a heap of depth TreeDepth below the root.
  localparam int unsigned TreeDepth = 6;
  localparam int unsigned IdxW      = TreeDepth + 1;
  localparam int unsigned RomSize   = (1 << IdxW) - 1;
  localparam int unsigned FirstLeaf = (1 << TreeDepth) - 1;

  // Byte codes of the input stream and of the output.
  localparam logic [7:0] SymDot   = 8'h2E;
  localparam logic [7:0] SymDash  = 8'h2D;
  localparam logic [7:0] SymSpace = 8'h20;
  localparam logic [7:0] Absent   = 8'h23;

  typedef logic [IdxW-1:0] node_idx_t;
  typedef logic [7:0]      char_t;

  // Heap-ordered character table; a dot goes to 2i+1 and a dash to 2i+2.
  localparam char_t CharRom [RomSize] = '{
    8'h23, 8'h45, 8'h54, 8'h49, 8'h41, 8'h4E, 8'h4D,
    8'h53, 8'h55, 8'h52, 8'h57, 8'h44, 8'h4B, 8'h47, 8'h4F,
    8'h48, 8'h56, 8'h46, 8'h23, 8'h4C, 8'h23, 8'h50, 8'h4A,
    8'h42, 8'h58, 8'h43, 8'h59, 8'h5A, 8'h51, 8'h23, 8'h23,
    8'h35, 8'h34, 8'h23, 8'h33, 8'h23, 8'h23, 8'h23, 8'h32,
    8'h26, 8'h23, 8'h2B, 8'h23, 8'h23, 8'h23, 8'h23, 8'h31,
    8'h36, 8'h3D, 8'h2F, 8'h23, 8'h23, 8'h23, 8'h28, 8'h23,
    8'h37, 8'h23, 8'h23, 8'hA5, 8'h38, 8'h23, 8'h39, 8'h30,
    8'h23, 8'h23, 8'h23, 8'h23, 8'h23, 8'h23, 8'h23, 8'h23,
    8'h23, 8'h23, 8'h23, 8'h23, 8'h3F, 8'h5F, 8'h23, 8'h23,
    8'h23, 8'h23, 8'h22, 8'h23, 8'h23, 8'h2E, 8'h23, 8'h23,
    8'h23, 8'h23, 8'h40, 8'h23, 8'h23, 8'h23, 8'h27, 8'h23,
    8'h23, 8'h2D, 8'h23, 8'h23, 8'h23, 8'h23, 8'h23, 8'h23,
    8'h23, 8'h23, 8'h3B, 8'h21, 8'h23, 8'h29, 8'h23, 8'h23,
    8'h23, 8'h23, 8'h23, 8'h2C, 8'h23, 8'h23, 8'h23, 8'h23,
    8'h3A, 8'h23, 8'h23, 8'h23, 8'h23, 8'h23, 8'h23, 8'h23
  };

endpackage

// File: rtl/morse_symbol_decoder_core.sv
// Path: a request that yields a character is held in the input register, then
// registered in the result register, from which it is presented at the output.
// Throughput: one request per cycle while the receiver does not stall a full result
// register; the node walk is one table read and one index update per request, so requests may follow back to back.
// Reset: rst_ni clears the stage valids, returns the walk to the tree root,
// marks the start of line as following a space and clears the overflow flag.
// ----------------------------------------------------------------------------
// morse_symbol_decoder_core
// Walks the Morse tree on dots and dashes and emits a character per gap and per line end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module morse_symbol_decoder_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          sym_byte_i,
  input  logic                line_end_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output msd_pkg::char_t      out_char_o
);
  import msd_pkg::*;

  logic      in_vq_q, in_vq_d;
  char_t     byte_q;
  logic      eol_q;
  node_idx_t node_q, node_d;
  logic      prev_q, prev_d;
  logic      ovf_q, ovf_d;
  logic      out_vq_q, out_vq_d;
  char_t     out_char_q, out_char_d;
  logic      emit;
  logic      adv;
  logic      proc;
  logic      accept;
  logic      right;
  char_t     pending;

  // The work stage advances whenever the result register is free or drained.
  assign adv        = !out_vq_q || !out_stall_i;
  assign proc       = in_vq_q && adv;
  assign in_stall_o = in_vq_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  // Character of the current node; an overflowed walk reads as absent.
  always_comb begin
    if (ovf_q || (node_q == node_idx_t'(RomSize))) begin
      pending = Absent;
    end else begin
      pending = CharRom[node_q];
    end
  end

  assign right = (byte_q == SymDash);

  // Tree walk and emission for the request held in the input register.
  always_comb begin
    node_d     = node_q;
    prev_d     = prev_q;
    ovf_d      = ovf_q;
    emit       = 1'b0;
    out_char_d = pending;
    if (proc) begin
      if (eol_q) begin
        emit   = 1'b1;
        node_d = '0;
        prev_d = 1'b1;
        ovf_d  = 1'b0;
      end else begin
        case (byte_q) inside
          SymSpace: begin
            emit = 1'b1;
            if (!prev_q) begin
              node_d = '0;
              ovf_d  = 1'b0;
            end else begin
              out_char_d = SymSpace;
            end
          end
          SymDot, SymDash: begin
            if (node_q >= node_idx_t'(FirstLeaf)) begin
              ovf_d = 1'b1;
            end else begin
              node_d = {node_q[IdxW-2:0], 1'b1} + node_idx_t'(right);
            end
          end
          default: begin
          end
        endcase
        prev_d = (byte_q == SymSpace);
      end
    end
  end

  // Stage valid flags.
  always_comb begin
    in_vq_d = in_vq_q;
    if (accept) begin
      in_vq_d = 1'b1;
    end else if (proc) begin
      in_vq_d = 1'b0;
    end
    out_vq_d = adv ? emit : out_vq_q;
  end

  // Control state with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq_q  <= 1'b0;
      out_vq_q <= 1'b0;
      node_q   <= '0;
      prev_q   <= 1'b1;
      ovf_q    <= 1'b0;
    end else begin
      in_vq_q  <= in_vq_d;
      out_vq_q <= out_vq_d;
      node_q   <= node_d;
      prev_q   <= prev_d;
      ovf_q    <= ovf_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= sym_byte_i;
      eol_q  <= line_end_i;
    end
    if (adv && emit) begin
      out_char_q <= out_char_d;
    end
  end

  assign out_valid_o = out_vq_q;
  assign out_char_o  = out_char_q;

  // The walk never reaches the index past the table.
  `MSD_ASSERT(a_node_in_rom, clk_i, rst_ni, node_q != node_idx_t'(RomSize), "node index out of table")
  // An overflowed walk only arises at the deepest level.
  `MSD_ASSERT(a_ovf_at_leaf, clk_i, rst_ni, ovf_q |-> (node_q >= node_idx_t'(FirstLeaf)), "overflow above leaf level")
  // Stall is raised only while a request is held.
  `MSD_ASSERT_ALWAYS(a_stall_held, clk_i, in_stall_o |-> in_vq_q, "stall without held request")
  // An end of line returns the walk to its start-of-line state.
  `MSD_ASSERT(a_eol_reset, clk_i, rst_ni, (proc && eol_q) |=> ((node_q == '0) && prev_q && !ovf_q && out_vq_q), "end of line did not reset the walk")

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for morse_symbol_decoder_core. Text bytes and line ends
// go in as requests; an internal tree walker predicts each decoded character,
// and every character that comes out is checked in order against it.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned TotalItems = 1550;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned TableSize  = 127;
  localparam int unsigned MaxDepth   = 6;

  // Heap-ordered Morse tree, root first; a dot goes to 2i+1 and a dash to 2i+2.
  localparam bit [8*TableSize-1:0] MorseTable = {
    "#ETIANM", "SURWDKGO", "HVF#L#PJ", "BXCYZQ##", "54#3###2", "&#+####1",
    "6=/###(#", "7##\2458#90", "########", "####?_##", "##\"##.##", "##@###'#",
    "#-######", "##;!#)##", "###,####", ":#######"
  };

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  logic [7:0]     sym_byte_i  = 8'h00;
  logic           line_end_i  = 1'b0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  msd_pkg::char_t out_char_o;

  // Walker state mirrored from the block.
  logic [6:0]     tree_node;
  logic           after_gap;
  logic           past_leaves;

  msd_pkg::char_t expected_chars[$];
  msd_pkg::char_t wanted_char;
  int unsigned    items_sent;
  int unsigned    error_count;
  int unsigned    cycle_count;
  int unsigned    hold_off_cycles;
  int unsigned    stall_left;
  int unsigned    stall_pct;
  bit             gaps_on;

  morse_symbol_decoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sym_byte_i  (sym_byte_i),
    .line_end_i  (line_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL morse_symbol_decoder_core");
      $finish;
    end
  end

  // Character at the current node; an overflowed walk always reads as absent.
  function automatic msd_pkg::char_t node_char();
    if (past_leaves || tree_node >= TableSize) return msd_pkg::Absent;
    return MorseTable[(TableSize - 1 - tree_node) * 8 +: 8];
  endfunction

  function automatic void restart_line();
    tree_node   = '0;
    after_gap   = 1'b1;
    past_leaves = 1'b0;
  endfunction

  // Advances the walker by one accepted request and queues any character due.
  function automatic void walk_morse_tree(logic [7:0] sym, logic eol);
    if (eol) begin
      expected_chars.push_back(node_char());
      restart_line();
      return;
    end
    if (sym == msd_pkg::SymSpace) begin
      if (after_gap) begin
        expected_chars.push_back(msd_pkg::SymSpace);
      end else begin
        expected_chars.push_back(node_char());
        tree_node   = '0;
        past_leaves = 1'b0;
      end
    end else if (sym == msd_pkg::SymDot || sym == msd_pkg::SymDash) begin
      if (tree_node >= (1 << MaxDepth) - 1) begin
        past_leaves = 1'b1;
      end else begin
        tree_node = 7'(2 * tree_node + ((sym == msd_pkg::SymDash) ? 2 : 1));
      end
    end
    after_gap = (sym == msd_pkg::SymSpace);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one request, waits for it to be taken, then may idle for a random gap.
  task automatic send_symbol(input logic [7:0] sym, input logic eol);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sym_byte_i <= sym;
    line_end_i <= eol;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    walk_morse_tree(sym, eol);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      send_symbol(text[i], 1'b0);
    end
  endtask

  // Receiver side: a forced hold-off first, then random stall bursts.
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_off_cycles = hold_off_cycles - 1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Checks every character taken from the block against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        error_count++;
        $display("%0t: out_char expected none, got 8'h%02h", $time, out_char_o);
      end else begin
        wanted_char = expected_chars.pop_front();
        if (out_char_o !== wanted_char) begin
          error_count++;
          $display("%0t: out_char expected 8'h%02h, got 8'h%02h",
                   $time, wanted_char, out_char_o);
        end
      end
    end
  end

  // Start of line, single letters, ignored bytes, the odd table entry and
  // a walk that runs past the deepest level.
  task automatic test_directed();
    gaps_on   = 1'b0;
    stall_pct = 0;
    send_text(" ");
    send_text(". ");
    send_text("- ");
    send_text(" ");
    send_symbol(msd_pkg::SymSpace, 1'b1);
    send_symbol(8'h00, 1'b0);
    send_text(" ");
    send_symbol(8'hFF, 1'b0);
    send_text("--.--");
    send_symbol(msd_pkg::SymDash, 1'b1);
    send_text("....... ");
  endtask

  // Requests back to back with an always-ready receiver.
  task automatic test_back_to_back();
    gaps_on   = 1'b0;
    stall_pct = 0;
    send_text(".----. ...--- --- -.-.-. ---...");
    send_symbol(msd_pkg::SymDot, 1'b1);
  endtask

  // The receiver holds off long enough for the block to fill and stall requests.
  task automatic test_receiver_hold_off();
    gaps_on   = 1'b0;
    stall_pct = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    hold_off_cycles = 200;
    repeat (20) send_text("-. ");
  endtask

  // Mostly well-formed codes with random content, the rest noise and line ends.
  task automatic test_random_text();
    int unsigned next_switch;
    int unsigned code_len;
    int unsigned roll;
    next_switch = 0;
    while (items_sent < TotalItems) begin
      if (items_sent >= next_switch) begin
        next_switch = items_sent + 150;
        roll        = $urandom_range(0, 2);
        gaps_on     = (roll != 0);
        stall_pct   = (roll == 0) ? 0 : ((roll == 1) ? 10 : 40);
      end
      if ($urandom_range(0, 99) < 80) begin
        code_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 6);
        for (int i = 0; i < code_len; i++) begin
          if ($urandom_range(0, 19) == 0) send_symbol(8'($urandom_range(0, 255)), 1'b0);
          send_symbol($urandom_range(0, 1) ? msd_pkg::SymDash : msd_pkg::SymDot, 1'b0);
        end
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          send_symbol(msd_pkg::SymSpace, 1'b0);
        end else if (roll < 85) begin
          send_text("  ");
        end else if (roll < 95) begin
          send_symbol(8'($urandom_range(0, 255)), 1'b1);
        end
      end else begin
        send_symbol(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
      end
    end
  endtask

  initial begin
    items_sent      = 0;
    error_count     = 0;
    cycle_count     = 0;
    hold_off_cycles = 0;
    stall_left      = 0;
    stall_pct       = 0;
    gaps_on         = 1'b0;
    restart_line();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_back_to_back();
    test_receiver_hold_off();
    test_random_text();

    // Drain whatever is still in flight.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS morse_symbol_decoder_core");
    end else begin
      $display("FAIL morse_symbol_decoder_core");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/msd_pkg.sv
rtl/morse_symbol_decoder_core.sv
tb/tb.sv
